[sv/acss_pkg.sv]
// shared types, codes, constants and digit decode for the alarm clock display
// no dependencies
package acss_pkg;

  typedef enum logic [2:0] {
    FN_TICK      = 3'd0,
    FN_SET_TIME  = 3'd1,
    FN_SET_ALARM = 3'd2,
    FN_ADJUST    = 3'd3,
    FN_END       = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ADJ_NONE   = 3'd0,
    ADJ_HOUR10 = 3'd1,
    ADJ_HOUR1  = 3'd2,
    ADJ_MIN10  = 3'd3,
    ADJ_MIN1   = 3'd4,
    ADJ_CLEAR  = 3'd5
  } adj_t;

  typedef enum logic [1:0] {
    TGT_NONE  = 2'd0,
    TGT_TIME  = 2'd1,
    TGT_ALARM = 2'd2
  } target_t;

  localparam logic [4:0] LAST_HOUR   = 5'd23;
  localparam logic [5:0] LAST_MINUTE = 6'd59;
  localparam logic [5:0] LAST_SECOND = 6'd59;
  localparam logic [5:0] HOURS_DAY   = 6'd24;
  localparam logic [6:0] MINS_HOUR   = 7'd60;
  localparam logic [4:0] NOON        = 5'd12;
  localparam logic [5:0] ALARM_SECS  = 6'd3;

  localparam logic [7:0] SEG_DP    = 8'h80;
  localparam logic [7:0] SEG_MSG_A = 8'h77;
  localparam logic [7:0] SEG_MSG_L = 8'h38;
  localparam logic [7:0] SEG_MSG_R = 8'h50;
  localparam logic [7:0] SEG_MSG_M = 8'h15;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [4:0] alarm_hours;
    logic [5:0] alarm_minutes;
    logic [4:0] edit_hours;
    logic [5:0] edit_minutes;
    target_t    edit_target;
  } clk_state_t;

  // digit codes above nine fold back as d mod 10
  function automatic logic [7:0] digit_seg(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0, 4'd10: s = 8'h3F;
      4'd1, 4'd11: s = 8'h06;
      4'd2, 4'd12: s = 8'h5B;
      4'd3, 4'd13: s = 8'h4F;
      4'd4, 4'd14: s = 8'h66;
      4'd5, 4'd15: s = 8'h6D;
      4'd6:        s = 8'h7D;
      4'd7:        s = 8'h07;
      4'd8:        s = 8'h7F;
      4'd9:        s = 8'h67;
      default:     s = 8'h3F;
    endcase
    return s;
  endfunction

  // tens pattern in the upper byte, ones pattern in the lower byte
  function automatic logic [15:0] seg_pair(input logic [5:0] v);
    logic [3:0] tens;
    logic [5:0] ones;
    if (v >= 6'd60)      tens = 4'd6;
    else if (v >= 6'd50) tens = 4'd5;
    else if (v >= 6'd40) tens = 4'd4;
    else if (v >= 6'd30) tens = 4'd3;
    else if (v >= 6'd20) tens = 4'd2;
    else if (v >= 6'd10) tens = 4'd1;
    else                 tens = 4'd0;
    ones = v - ({2'b00, tens} * 6'd10);
    return {digit_seg(tens), digit_seg(ones[3:0])};
  endfunction

endpackage

[sv/acss_core.sv]
// time, alarm and edit-session registers with their update logic
// depends on acss_pkg
module acss_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  acss_pkg::func_t     func,
  input  acss_pkg::adj_t      adj,
  output acss_pkg::clk_state_t st_nxt
);
  import acss_pkg::*;

  clk_state_t st_r;
  logic [5:0] eh;
  logic [6:0] em;

  always_comb begin
    st_nxt = st_r;
    eh     = {1'b0, st_r.edit_hours};
    em     = {1'b0, st_r.edit_minutes};
    if (step) begin
      case (func)
        FN_TICK: begin
          // clock halts while a session is open
          if (st_r.edit_target == TGT_NONE) begin
            if (st_r.seconds == LAST_SECOND) begin
              st_nxt.seconds = '0;
              if (st_r.minutes == LAST_MINUTE) begin
                st_nxt.minutes = '0;
                st_nxt.hours   = (st_r.hours == LAST_HOUR) ? '0 : st_r.hours + 5'd1;
              end else begin
                st_nxt.minutes = st_r.minutes + 6'd1;
              end
            end else begin
              st_nxt.seconds = st_r.seconds + 6'd1;
            end
          end
        end
        FN_SET_TIME, FN_SET_ALARM: begin
          if (st_r.edit_target == TGT_NONE) begin
            st_nxt.edit_hours   = st_r.hours;
            st_nxt.edit_minutes = st_r.minutes;
            st_nxt.edit_target  = (func == FN_SET_TIME) ? TGT_TIME : TGT_ALARM;
          end
        end
        FN_ADJUST: begin
          if (st_r.edit_target != TGT_NONE) begin
            case (adj)
              ADJ_HOUR10: eh = eh + 6'd10;
              ADJ_HOUR1:  eh = eh + 6'd1;
              ADJ_MIN10:  em = em + 7'd10;
              ADJ_MIN1:   em = em + 7'd1;
              ADJ_CLEAR: begin
                eh = '0;
                em = '0;
              end
              default: ;
            endcase
            if (eh >= HOURS_DAY) eh = '0;
            if (em >= MINS_HOUR) em = '0;
            st_nxt.edit_hours   = eh[4:0];
            st_nxt.edit_minutes = em[5:0];
          end
        end
        FN_END: begin
          case (st_r.edit_target)
            TGT_TIME: begin
              st_nxt.hours   = st_r.edit_hours;
              st_nxt.minutes = st_r.edit_minutes;
              st_nxt.seconds = '0;
            end
            TGT_ALARM: begin
              st_nxt.alarm_hours   = st_r.edit_hours;
              st_nxt.alarm_minutes = st_r.edit_minutes;
              st_nxt.seconds       = '0;
            end
            default: ;
          endcase
          st_nxt.edit_target = TGT_NONE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.hours <= LAST_HOUR && st_r.minutes <= LAST_MINUTE && st_r.seconds <= LAST_SECOND)
    else $error("clock time out of range");

  a_edit_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.edit_hours <= LAST_HOUR && st_r.edit_minutes <= LAST_MINUTE)
    else $error("edit value out of range");

  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.edit_target != TGT_NONE && !(step && func == FN_END) |=>
      $stable(st_r.hours) && $stable(st_r.minutes) && $stable(st_r.seconds))
    else $error("clock moved during a set session");
`endif

endmodule

[sv/acss_disp.sv]
// seven-segment encoding of the edit value, alarm message or clock time
// depends on acss_pkg
module acss_disp (
  input  acss_pkg::clk_state_t st,
  input  logic                 twelve_hour,
  output logic [7:0]           seg_first,
  output logic [7:0]           seg_second,
  output logic [7:0]           seg_third,
  output logic [7:0]           seg_fourth,
  output logic                 alarm_on,
  output logic                 setting
);
  import acss_pkg::*;

  logic [4:0]  h_show;
  logic [15:0] hh_seg;
  logic [15:0] mm_seg;
  logic [15:0] eh_seg;
  logic [15:0] em_seg;
  logic        pm;

  always_comb begin
    h_show = st.hours;
    if (twelve_hour) begin
      if (st.hours == '0)      h_show = NOON;
      else if (st.hours > NOON) h_show = st.hours - NOON;
    end
  end

  assign pm     = twelve_hour && (st.hours >= NOON);
  assign hh_seg = seg_pair({1'b0, h_show});
  assign mm_seg = seg_pair(st.minutes);
  assign eh_seg = seg_pair({1'b0, st.edit_hours});
  assign em_seg = seg_pair(st.edit_minutes);

  always_comb begin
    alarm_on = 1'b0;
    setting  = 1'b0;
    if (st.edit_target != TGT_NONE) begin
      setting    = 1'b1;
      seg_first  = eh_seg[15:8];
      seg_second = eh_seg[7:0];
      seg_third  = em_seg[15:8];
      seg_fourth = em_seg[7:0];
    end else if (st.alarm_hours == st.hours && st.alarm_minutes == st.minutes &&
                 st.seconds < ALARM_SECS) begin
      alarm_on   = 1'b1;
      seg_first  = SEG_MSG_A;
      seg_second = SEG_MSG_L;
      seg_third  = SEG_MSG_R;
      seg_fourth = SEG_MSG_M;
    end else begin
      seg_first  = hh_seg[15:8] | (pm ? SEG_DP : 8'h00);
      seg_second = hh_seg[7:0]  | (pm ? SEG_DP : 8'h00);
      seg_third  = mm_seg[15:8];
      seg_fourth = mm_seg[7:0]  | (twelve_hour ? SEG_DP : 8'h00);
    end
  end

endmodule

[sv/alarm_clock_seven_segment.sv]
// path: a beat accepted into the input register moves to the result register once
//   that register is empty or out_tready takes its beat, and is offered from there
// throughput: one beat per cycle; the input register stalls only while the
//   result register holds a beat that out_tready has not taken
// reset: rst_n low clears time, alarm, edit values and session to zero
// and empties both registers
module alarm_clock_seven_segment (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // func[2:0], adjust[5:3], twelve_hour[6], zero[7]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // seg_first[7:0], seg_second[15:8], seg_third[23:16],
                                  // seg_fourth[31:24]
  output logic [1:0]  out_tuser   // alarm_on[0], setting[1]
);
  import acss_pkg::*;

  logic       in_valid_r;
  func_t      in_func_r;
  adj_t       in_adj_r;
  logic       in_twelve_r;
  logic       out_valid_r;
  logic [31:0] out_data_r;
  logic [1:0]  out_user_r;
  logic        adv;
  logic        in_acc;

  clk_state_t st_nxt;
  logic [7:0] seg_first;
  logic [7:0] seg_second;
  logic [7:0] seg_third;
  logic [7:0] seg_fourth;
  logic       alarm_on;
  logic       setting;

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_acc) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_func_r   <= func_t'(in_tdata[2:0]);
      in_adj_r    <= adj_t'(in_tdata[5:3]);
      in_twelve_r <= in_tdata[6];
    end
  end

  acss_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (adv),
    .func   (in_func_r),
    .adj    (in_adj_r),
    .st_nxt (st_nxt)
  );

  acss_disp u_disp (
    .st          (st_nxt),
    .twelve_hour (in_twelve_r),
    .seg_first   (seg_first),
    .seg_second  (seg_second),
    .seg_third   (seg_third),
    .seg_fourth  (seg_fourth),
    .alarm_on    (alarm_on),
    .setting     (setting)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {seg_fourth, seg_third, seg_second, seg_first};
      out_user_r <= {setting, alarm_on};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef NO_ASSERTIONS
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_user_r[0] && out_user_r[1]))
    else $error("alarm and setting flags both set");

  a_setting_no_dp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_user_r[1] |->
      !out_data_r[7] && !out_data_r[15] && !out_data_r[23] && !out_data_r[31])
    else $error("decimal point lit while setting");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> $stable(out_data_r) && $stable(out_user_r))
    else $error("pending result overwritten");
`endif

endmodule
